/* hdl/c3z_pkg.sv */
package c3z_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W       = 8;
  localparam int TAP_W       = 8;
  localparam int PSUM_W      = 19;
  localparam int SUM_W       = 21;
  localparam int CFG_DIM_W   = 11;
  localparam int CFG_TAPS_W  = 24;
  localparam int CFG_SHIFT_W = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_DIM_W-1:0]   RST_WIDTH   = 11'd1024;
  localparam logic [CFG_DIM_W-1:0]   RST_HEIGHT  = 11'd1024;
  localparam logic [CFG_TAPS_W-1:0]  RST_TAPS_T  = 24'd256;
  localparam logic [CFG_TAPS_W-1:0]  RST_TAPS_M  = 24'd66561;
  localparam logic [CFG_TAPS_W-1:0]  RST_TAPS_B  = 24'd256;
  localparam logic [CFG_SHIFT_W-1:0] RST_SHIFT   = 4'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_TAPS_TOP = 3'd2,
    REG_TAPS_MID = 3'd3,
    REG_TAPS_BOT = 3'd4,
    REG_SHIFT    = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  typedef struct packed {
    logic signed [TAP_W-1:0] top;
    logic signed [TAP_W-1:0] mid;
    logic signed [TAP_W-1:0] bot;
  } taps_t;

  typedef struct packed {
    logic col;
    logic top;
    logic bot;
  } zero_t;

endpackage

/* hdl/c3z_ram.sv */
module c3z_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

/* hdl/c3z_cell.sv */
module c3z_cell import c3z_pkg::*; (
  input  logic                     clk_i,
  input  logic                     shift_en_i,
  input  logic                     calc_en_i,
  input  col_t                     col_i,
  input  taps_t                    taps_i,
  input  zero_t                    zero_i,
  output col_t                     col_o,
  output logic signed [PSUM_W-1:0] psum_o
);

  col_t                     col_q;
  logic signed [PSUM_W-1:0] psum_d, psum_q;
  logic signed [PIX_W:0]    top_s, mid_s, bot_s;

  always_comb begin
    top_s = (zero_i.col || zero_i.top) ? '0 : $signed({1'b0, col_i.top});
    mid_s = zero_i.col ? '0 : $signed({1'b0, col_i.mid});
    bot_s = (zero_i.col || zero_i.bot) ? '0 : $signed({1'b0, col_i.bot});
    psum_d = PSUM_W'(top_s * taps_i.top) + PSUM_W'(mid_s * taps_i.mid)
           + PSUM_W'(bot_s * taps_i.bot);
  end

  always_ff @(posedge clk_i) begin
    if (shift_en_i) begin
      col_q <= col_i;
    end
    if (calc_en_i) begin
      psum_q <= psum_d;
    end
  end

  assign col_o  = col_q;
  assign psum_o = psum_q;

endmodule

/* hdl/conv3x3_zero_pad_stream_core.sv */
// channel   direction  signals                                  fields
// s_axis    in         s_axis_tvalid/tready/tdata/tuser         tdata: pixel_in, tuser: drain
// m_axis    out        m_axis_tvalid/tready/tdata/tlast         tdata: pixel_out, tlast: frame_last
// cfg       in         cfg_valid_i/cfg_ready_o/cfg_index_i/data register index and value
//
// one word per cycle unless the output is held; words pass stage 1 and cell registers to the output
// line buffer ram (two rows, one read and one write port) and the three window cells
// hold the neighborhood; the pipeline stalls as a whole only when the output is held
// reset clears counters and valid bits, no clearing pass over the line buffer
module conv3x3_zero_pad_stream_core import c3z_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,  // pixel_in
  input  logic [0:0]            s_axis_tuser,  // drain
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [7:0]            m_axis_tdata,  // pixel_out
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int ORW = $clog2(MAX_HEIGHT);
  localparam int WDW = $clog2(MAX_WIDTH + 1);
  localparam int HDW = $clog2(MAX_HEIGHT + 1);
  localparam int LBW = 2 * PIX_W;

  logic [CFG_DIM_W-1:0]   width_q, height_q;
  logic [CFG_TAPS_W-1:0]  taps_t_q, taps_m_q, taps_b_q;
  logic [CFG_SHIFT_W-1:0] shift_q;
  logic                   cfg_we, restart;

  logic [WDW-1:0] wd;
  logic [HDW-1:0] ht;

  logic [CW-1:0]  in_col_q, in_col_d, out_col_q, out_col_d;
  logic [RW-1:0]  in_row_q, in_row_d;
  logic [ORW-1:0] out_row_q, out_row_d;

  logic adv, acc, drop, push, emit, col_end, in_img;
  logic oj_l, oj_r, oi_t, oi_b, last;

  logic             s1_valid_q, s1_emit_q, s1_last_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_addr_q;
  zero_t            s1_zl_q, s1_zc_q, s1_zr_q;
  logic             fwd_q;
  logic [LBW-1:0]   fwd_data_q, rd_data, rd_mix, wr_data;
  logic             wr_en;

  logic s2_valid_q, s2_last_q;
  logic out_valid_q, out_last_q;
  logic [PIX_W-1:0] out_pix_q, out_pix_d;

  col_t  col_new, col_r, col_c;
  taps_t taps_l, taps_c, taps_r;
  logic signed [PSUM_W-1:0] ps_l, ps_c, ps_r;
  logic signed [SUM_W-1:0]  sum, shifted;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;
  assign restart     = cfg_we && (cfg_reg_e'(cfg_index_i) == REG_WIDTH ||
                                  cfg_reg_e'(cfg_index_i) == REG_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_WIDTH;
      height_q <= RST_HEIGHT;
      taps_t_q <= RST_TAPS_T;
      taps_m_q <= RST_TAPS_M;
      taps_b_q <= RST_TAPS_B;
      shift_q  <= RST_SHIFT;
    end else if (cfg_we) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_WIDTH:    width_q  <= cfg_data_i[CFG_DIM_W-1:0];
        REG_HEIGHT:   height_q <= cfg_data_i[CFG_DIM_W-1:0];
        REG_TAPS_TOP: taps_t_q <= cfg_data_i[CFG_TAPS_W-1:0];
        REG_TAPS_MID: taps_m_q <= cfg_data_i[CFG_TAPS_W-1:0];
        REG_TAPS_BOT: taps_b_q <= cfg_data_i[CFG_TAPS_W-1:0];
        REG_SHIFT:    shift_q  <= cfg_data_i[CFG_SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_q == '0) begin
      wd = WDW'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      wd = WDW'(MAX_WIDTH);
    end else begin
      wd = WDW'(width_q);
    end
    if (height_q == '0) begin
      ht = HDW'(1);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      ht = HDW'(MAX_HEIGHT);
    end else begin
      ht = HDW'(height_q);
    end
  end

  // input and output position tracking
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && adv;
  assign in_img        = in_row_q < RW'(ht);
  assign drop          = s_axis_tuser[0] && in_img;
  assign push          = acc && !drop;
  assign emit          = (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
  assign col_end       = WDW'(in_col_q) == wd - WDW'(1);
  assign oj_l          = out_col_q == '0;
  assign oj_r          = WDW'(out_col_q) == wd - WDW'(1);
  assign oi_t          = out_row_q == '0;
  assign oi_b          = HDW'(out_row_q) == ht - HDW'(1);
  assign last          = oi_b && oj_r;

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    if (push) begin
      if (col_end) begin
        in_col_d = '0;
        in_row_d = in_row_q + RW'(1);
      end else begin
        in_col_d = in_col_q + CW'(1);
      end
      if (emit) begin
        if (oj_r) begin
          out_col_d = '0;
          out_row_d = out_row_q + ORW'(1);
        end else begin
          out_col_d = out_col_q + CW'(1);
        end
      end
      if (emit && last) begin
        in_col_d  = '0;
        in_row_d  = '0;
        out_col_d = '0;
        out_row_d = '0;
      end
    end
    if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

  // stage 1: line buffer read, stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= push;
      s2_valid_q  <= s1_valid_q && s1_emit_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_emit_q  <= emit;
      s1_last_q  <= last;
      s1_pix_q   <= in_img ? s_axis_tdata : '0;
      s1_addr_q  <= in_col_q;
      s1_zl_q    <= '{col: oj_l, top: oi_t, bot: oi_b};
      s1_zc_q    <= '{col: 1'b0, top: oi_t, bot: oi_b};
      s1_zr_q    <= '{col: oj_r, top: oi_t, bot: oi_b};
      fwd_q      <= wr_en && (s1_addr_q == in_col_q);
      fwd_data_q <= wr_data;
    end
    if (adv) begin
      s2_last_q  <= s1_last_q;
      out_last_q <= s2_last_q;
      out_pix_q  <= out_pix_d;
    end
  end

  assign rd_mix  = fwd_q ? fwd_data_q : rd_data;
  assign wr_en   = adv && s1_valid_q;
  assign wr_data = {rd_mix[PIX_W-1:0], s1_pix_q};

  c3z_ram #(
    .WIDTH (LBW),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_addr_q),
    .wr_data_i (wr_data),
    .rd_en_i   (acc),
    .rd_addr_i (in_col_q),
    .rd_data_o (rd_data)
  );

  // stage 2: window cells
  assign col_new = '{top: rd_mix[LBW-1:PIX_W], mid: rd_mix[PIX_W-1:0], bot: s1_pix_q};
  assign taps_l  = '{top: taps_t_q[23:16], mid: taps_m_q[23:16], bot: taps_b_q[23:16]};
  assign taps_c  = '{top: taps_t_q[15:8],  mid: taps_m_q[15:8],  bot: taps_b_q[15:8]};
  assign taps_r  = '{top: taps_t_q[7:0],   mid: taps_m_q[7:0],   bot: taps_b_q[7:0]};

  c3z_cell u_cell_r (
    .clk_i      (clk_i),
    .shift_en_i (wr_en),
    .calc_en_i  (adv),
    .col_i      (col_new),
    .taps_i     (taps_r),
    .zero_i     (s1_zr_q),
    .col_o      (col_r),
    .psum_o     (ps_r)
  );

  c3z_cell u_cell_c (
    .clk_i      (clk_i),
    .shift_en_i (wr_en),
    .calc_en_i  (adv),
    .col_i      (col_r),
    .taps_i     (taps_c),
    .zero_i     (s1_zc_q),
    .col_o      (col_c),
    .psum_o     (ps_c)
  );

  c3z_cell u_cell_l (
    .clk_i      (clk_i),
    .shift_en_i (wr_en),
    .calc_en_i  (adv),
    .col_i      (col_c),
    .taps_i     (taps_l),
    .zero_i     (s1_zl_q),
    .col_o      (),
    .psum_o     (ps_l)
  );

  // stage 3: sum, shift, saturate
  always_comb begin
    sum     = SUM_W'(ps_l) + SUM_W'(ps_c) + SUM_W'(ps_r);
    shifted = sum >>> shift_q;
    if (shifted < 0) begin
      out_pix_d = '0;
    end else if (shifted > SUM_W'(255)) begin
      out_pix_d = '1;
    end else begin
      out_pix_d = shifted[PIX_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

endmodule
